>>> rtl/lrgbycc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrgbycc_pkg;

   // Channel lanes.
   localparam int LANES    = 3;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Field and datapath widths.
   localparam int LIN_W   = 24;   // signed Q4.20 linear input
   localparam int MAG_W   = 24;   // magnitude, up to 2^23 for the most negative input
   localparam int EXP_W   = 5;    // leading-one position
   localparam int OCT_W   = 4;    // octave number within the curve table
   localparam int GAM_W   = 28;   // signed gamma-coded value, 24 fraction bits
   localparam int LINW_W  = 25;   // scaled magnitude on the linear segment
   localparam int LING_W  = 20;   // gamma value on the linear segment
   localparam int ACC_W   = 45;   // matrix sum, 40 fraction bits
   localparam int COEF_W  = 17;   // signed Q16 matrix coefficient
   localparam int RES_W   = 8;
   localparam int RES_LSB = 32;

   // sRGB curve geometry.
   localparam int OCT_LOW   = 11;
   localparam int OCT_COUNT = 13;
   localparam int TOP_EXP   = 23;
   localparam logic [MAG_W-1:0] KNEE_MAG = 24'd3282;

   // Linear segment: round(m * 206.72) = floor((m * 5168 + 12) / 25).
   localparam logic [12:0] LIN_MUL   = 13'd5168;
   localparam logic [4:0]  LIN_BIAS  = 5'd12;
   localparam logic [25:0] RECIP25   = 26'd42949673;   // ceil(2^30 / 25)
   localparam int          RECIP_SH  = 30;
   localparam int          RECIP_PW  = LINW_W + 26;

   // JFIF matrix, Q16.
   localparam logic signed [COEF_W-1:0] Y_R  = 17'sd19595;
   localparam logic signed [COEF_W-1:0] Y_G  = 17'sd38470;
   localparam logic signed [COEF_W-1:0] Y_B  = 17'sd7471;
   localparam logic signed [COEF_W-1:0] CB_R = -17'sd11059;
   localparam logic signed [COEF_W-1:0] CB_G = -17'sd21709;
   localparam logic signed [COEF_W-1:0] CB_B = 17'sd32768;
   localparam logic signed [COEF_W-1:0] CR_R = 17'sd32768;
   localparam logic signed [COEF_W-1:0] CR_G = -17'sd27439;
   localparam logic signed [COEF_W-1:0] CR_B = -17'sd5329;

   localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 45'sh0_8000_0000_00;  // 2^39
   localparam logic signed [ACC_W-1:0] ACC_ONE       = 45'sh1_0000_0000_00;  // 2^40
   localparam logic [RES_W-1:0]        RES_MAX       = 8'hFF;

   typedef logic [LANES-1:0][LIN_W-1:0] lin_vec_type;
   typedef logic [LANES-1:0][GAM_W-1:0] gamma_vec_type;

   // Largest Y with Y^12 <= x^5 * 2^236, i.e. floor(2^28 * (x / 2^20)^(5/12)).
   // Evaluated only at elaboration to build the curve table.
   function automatic logic [29:0] root_5_12(input logic [24:0] x);
      logic [383:0] tgt;
      logic [383:0] pw;
      logic [383:0] m1;
      logic [383:0] m2;
      logic [383:0] m3;
      logic [383:0] m6;
      logic [383:0] m12;
      logic [30:0]  lo;
      logic [30:0]  hi;
      logic [30:0]  mid;
      tgt = 384'(x);
      pw  = tgt * tgt;
      pw  = pw * tgt;
      pw  = pw * tgt;
      pw  = pw * tgt;
      tgt = pw << 236;
      lo  = 31'd0;
      hi  = 31'd1 << 30;
      for (int k = 0; k < 32; k++) begin
         if ((hi - lo) > 31'd1) begin
            mid = lo + ((hi - lo) >> 1);
            m1  = 384'(mid);
            m2  = m1 * m1;
            m3  = m2 * m1;
            m6  = m3 * m3;
            m12 = m6 * m6;
            if (m12 <= tgt) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
      end
      return lo[29:0];
   endfunction

   // Gamma-coded value at one curve node.
   function automatic logic signed [GAM_W-1:0] curve_node(input int unsigned node,
                                                           input int unsigned seg_bits);
      int unsigned e;
      int unsigned seg;
      logic [24:0] x;
      longint      y;
      longint      v;
      e   = OCT_LOW + (node >> seg_bits);
      seg = node & ((32'd1 << seg_bits) - 32'd1);
      x   = (25'd1 << e) + (25'(seg) << (e - seg_bits));
      y   = longint'(root_5_12(x));
      v   = (1055 * y + 8000) / 16000 - 922747;
      return GAM_W'(v);
   endfunction

   // Scale a matrix sum to 8 bits with clamping at both ends.
   function automatic logic [RES_W-1:0] clamp8(input logic signed [ACC_W-1:0] acc);
      logic [RES_W-1:0] res;
      if (acc <= 0) begin
         res = '0;
      end else if (acc >= ACC_ONE) begin
         res = RES_MAX;
      end else begin
         res = acc[RES_LSB +: RES_W];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/lrgbycc_gamma.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-stage sRGB transfer curve for three channels in parallel.
module lrgbycc_gamma
   import lrgbycc_pkg::*;
#(
   parameter int CURVE_TABLE_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  lin_vec_type   in_lin,
   output logic          out_valid,
   input  logic          out_ready,
   output gamma_vec_type out_gamma
);

   localparam int STAGES   = 4;
   localparam int SEG_BITS = CURVE_TABLE_BITS - 4;
   localparam int SEGS     = 1 << SEG_BITS;
   localparam int NODES    = OCT_COUNT * SEGS + 1;
   localparam int IDX_W    = $clog2(NODES);
   localparam int SH_MAX   = TOP_EXP - SEG_BITS;
   localparam int SH_W     = $clog2(SH_MAX + 1);
   localparam int DIFF_W   = GAM_W - 1;
   localparam int PROD_W   = DIFF_W + SH_MAX;

   // Curve node table, built at elaboration.
   logic signed [GAM_W-1:0] curve_rom [NODES];

   for (genvar n = 0; n < NODES; n++) begin : g_rom
      localparam logic signed [GAM_W-1:0] NODE_VAL = curve_node(n, SEG_BITS);
      assign curve_rom[n] = NODE_VAL;
   end

   // Pipeline control: valid bits and per-stage load enables.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   stage_go;

   always_comb begin
      stage_go[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_go[k] = !valid_ff[k] || stage_go[k+1];
      end
      valid_in = {valid_ff[STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_go[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign in_ready  = stage_go[0];
   assign out_valid = valid_ff[STAGES-1];

   // Stage 1 registers: sign, segment decode and linear-segment product.
   logic [LANES-1:0] s1_neg_ff, s1_neg_in;
   logic [LANES-1:0] s1_knee_ff, s1_knee_in;
   logic [IDX_W-1:0]  s1_idx_ff [LANES];
   logic [IDX_W-1:0]  s1_idx_in [LANES];
   logic [SH_MAX-1:0] s1_t_ff [LANES];
   logic [SH_MAX-1:0] s1_t_in [LANES];
   logic [SH_W-1:0]   s1_sh_ff [LANES];
   logic [SH_W-1:0]   s1_sh_in [LANES];
   logic [LINW_W-1:0] s1_w_ff [LANES];
   logic [LINW_W-1:0] s1_w_in [LANES];

   // Stage 2 registers: table nodes and linear-segment quotient.
   logic [LANES-1:0] s2_neg_ff, s2_knee_ff;
   logic signed [GAM_W-1:0] s2_base_ff [LANES];
   logic signed [GAM_W-1:0] s2_base_in [LANES];
   logic [DIFF_W-1:0] s2_diff_ff [LANES];
   logic [DIFF_W-1:0] s2_diff_in [LANES];
   logic [SH_MAX-1:0] s2_t_ff [LANES];
   logic [SH_W-1:0]   s2_sh_ff [LANES];
   logic [LING_W-1:0] s2_lin_ff [LANES];
   logic [LING_W-1:0] s2_lin_in [LANES];
   logic signed [GAM_W-1:0] diff_full [LANES];

   // Stage 3 registers: interpolation product.
   logic [LANES-1:0] s3_neg_ff, s3_knee_ff;
   logic signed [GAM_W-1:0] s3_base_ff [LANES];
   logic [PROD_W-1:0] s3_prod_ff [LANES];
   logic [PROD_W-1:0] s3_prod_in [LANES];
   logic [SH_W-1:0]   s3_sh_ff [LANES];
   logic [LING_W-1:0] s3_lin_ff [LANES];

   // Stage 4 registers: signed gamma-coded value.
   logic signed [GAM_W-1:0] s4_gamma_ff [LANES];
   logic signed [GAM_W-1:0] s4_gamma_in [LANES];
   logic [PROD_W-1:0] frac_full [LANES];

   // Stage 1 logic: magnitude, leading one, table index and remainder.
   always_comb begin : p_decode
      logic [MAG_W-1:0] raw;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] rem;
      logic [EXP_W-1:0] e;
      logic [SH_W-1:0]  sh;
      logic [OCT_W-1:0] oct;
      logic [SEG_BITS-1:0] seg;
      for (int ln = 0; ln < LANES; ln++) begin
         raw = in_lin[ln];
         s1_neg_in[ln] = raw[MAG_W-1];
         mag = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
         s1_knee_in[ln] = (mag <= KNEE_MAG);
         e = '0;
         for (int b = 0; b < MAG_W; b++) begin
            if (mag[b]) begin
               e = EXP_W'(b);
            end
         end
         rem = mag & ~(MAG_W'(1) << e);
         sh  = SH_W'(e - EXP_W'(SEG_BITS));
         oct = OCT_W'(e - EXP_W'(OCT_LOW));
         seg = SEG_BITS'(rem >> sh);
         s1_idx_in[ln] = IDX_W'({oct, seg});
         s1_t_in[ln]   = SH_MAX'(rem) & ~({SH_MAX{1'b1}} << sh);
         s1_sh_in[ln]  = sh;
         s1_w_in[ln]   = LINW_W'(mag[11:0]) * LINW_W'(LIN_MUL) + LINW_W'(LIN_BIAS);
      end
   end

   // Stage 2 logic: node lookup and division by 25 through a reciprocal.
   always_comb begin : p_lookup
      logic signed [GAM_W-1:0] nxt;
      logic [RECIP_PW-1:0]     qprod;
      for (int ln = 0; ln < LANES; ln++) begin
         s2_base_in[ln] = curve_rom[s1_idx_ff[ln]];
         nxt            = curve_rom[IDX_W'(s1_idx_ff[ln] + 1'b1)];
         diff_full[ln]  = nxt - s2_base_in[ln];
         s2_diff_in[ln] = diff_full[ln][DIFF_W-1:0];
         qprod          = RECIP_PW'(s1_w_ff[ln]) * RECIP_PW'(RECIP25);
         s2_lin_in[ln]  = qprod[RECIP_SH +: LING_W];
      end
   end

   // Stage 3 logic: slope times position within the segment.
   always_comb begin : p_interp
      for (int ln = 0; ln < LANES; ln++) begin
         s3_prod_in[ln] = PROD_W'(s2_diff_ff[ln]) * PROD_W'(s2_t_ff[ln]);
      end
   end

   // Stage 4 logic: pick the segment, add the fraction and restore the sign.
   always_comb begin : p_finish
      logic [DIFF_W-1:0]       magg;
      logic signed [GAM_W-1:0] gpos;
      for (int ln = 0; ln < LANES; ln++) begin
         frac_full[ln] = s3_prod_ff[ln] >> s3_sh_ff[ln];
         if (s3_knee_ff[ln]) begin
            magg = DIFF_W'(s3_lin_ff[ln]);
         end else begin
            magg = s3_base_ff[ln][DIFF_W-1:0] + frac_full[ln][DIFF_W-1:0];
         end
         gpos = {1'b0, magg};
         s4_gamma_in[ln] = s3_neg_ff[ln] ? -gpos : gpos;
      end
   end

   // Datapath registers, loaded as their stage advances.
   always_ff @(posedge clock) begin
      if (stage_go[0]) begin
         s1_neg_ff  <= s1_neg_in;
         s1_knee_ff <= s1_knee_in;
         s1_idx_ff  <= s1_idx_in;
         s1_t_ff    <= s1_t_in;
         s1_sh_ff   <= s1_sh_in;
         s1_w_ff    <= s1_w_in;
      end
      if (stage_go[1]) begin
         s2_neg_ff  <= s1_neg_ff;
         s2_knee_ff <= s1_knee_ff;
         s2_base_ff <= s2_base_in;
         s2_diff_ff <= s2_diff_in;
         s2_t_ff    <= s1_t_ff;
         s2_sh_ff   <= s1_sh_ff;
         s2_lin_ff  <= s2_lin_in;
      end
      if (stage_go[2]) begin
         s3_neg_ff  <= s2_neg_ff;
         s3_knee_ff <= s2_knee_ff;
         s3_base_ff <= s2_base_ff;
         s3_prod_ff <= s3_prod_in;
         s3_sh_ff   <= s2_sh_ff;
         s3_lin_ff  <= s2_lin_ff;
      end
      if (stage_go[3]) begin
         s4_gamma_ff <= s4_gamma_in;
      end
   end

   always_comb begin
      for (int ln = 0; ln < LANES; ln++) begin
         out_gamma[ln] = s4_gamma_ff[ln];
      end
   end

   // The curve is monotonic, the interpolated step stays inside one segment,
   // and a negative input never codes to a positive value.
   for (genvar ln = 0; ln < LANES; ln++) begin : g_chk
      a_slope_nonneg: assert property (@(posedge clock) disable iff (reset)
         valid_ff[0] && !s1_knee_ff[ln] |-> !diff_full[ln][GAM_W-1])
         else $error("curve table slope is negative");
      a_frac_fits: assert property (@(posedge clock) disable iff (reset)
         valid_ff[2] && !s3_knee_ff[ln] |-> (frac_full[ln] >> DIFF_W) == '0)
         else $error("interpolation step overflows the segment");
      a_odd_mirror: assert property (@(posedge clock) disable iff (reset)
         valid_ff[2] && stage_go[3] && s3_neg_ff[ln] |=> s4_gamma_ff[ln] <= 0)
         else $error("negative input gave a positive coded value");
   end

endmodule

`default_nettype wire

>>> rtl/lrgbycc_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-stage JFIF YCbCr matrix with 8-bit clamping.
module lrgbycc_matrix
   import lrgbycc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  gamma_vec_type    in_gamma,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [RES_W-1:0] out_luma,
   output logic [RES_W-1:0] out_chroma_blue,
   output logic [RES_W-1:0] out_chroma_red
);

   localparam int STAGES = 3;

   // Pipeline control: valid bits and per-stage load enables.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   stage_go;

   always_comb begin
      stage_go[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_go[k] = !valid_ff[k] || stage_go[k+1];
      end
      valid_in = {valid_ff[STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_go[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign in_ready  = stage_go[0];
   assign out_valid = valid_ff[STAGES-1];

   // Stage 1: the nine coefficient products.
   logic signed [GAM_W-1:0] g_r, g_g, g_b;
   logic signed [ACC_W-1:0] p_yr_ff, p_yg_ff, p_yb_ff, p_yr_in, p_yg_in, p_yb_in;
   logic signed [ACC_W-1:0] p_br_ff, p_bg_ff, p_bb_ff, p_br_in, p_bg_in, p_bb_in;
   logic signed [ACC_W-1:0] p_rr_ff, p_rg_ff, p_rb_ff, p_rr_in, p_rg_in, p_rb_in;
   logic m1_neutral_ff, m1_neutral_in;

   always_comb begin
      g_r = $signed(in_gamma[CH_RED]);
      g_g = $signed(in_gamma[CH_GREEN]);
      g_b = $signed(in_gamma[CH_BLUE]);
      p_yr_in = ACC_W'(Y_R)  * ACC_W'(g_r);
      p_yg_in = ACC_W'(Y_G)  * ACC_W'(g_g);
      p_yb_in = ACC_W'(Y_B)  * ACC_W'(g_b);
      p_br_in = ACC_W'(CB_R) * ACC_W'(g_r);
      p_bg_in = ACC_W'(CB_G) * ACC_W'(g_g);
      p_bb_in = ACC_W'(CB_B) * ACC_W'(g_b);
      p_rr_in = ACC_W'(CR_R) * ACC_W'(g_r);
      p_rg_in = ACC_W'(CR_G) * ACC_W'(g_g);
      p_rb_in = ACC_W'(CR_B) * ACC_W'(g_b);
      m1_neutral_in = (g_r == g_g) && (g_g == g_b);
   end

   // Stage 2: row sums, with the chroma offset.
   logic signed [ACC_W-1:0] acc_y_ff, acc_cb_ff, acc_cr_ff;
   logic signed [ACC_W-1:0] acc_y_in, acc_cb_in, acc_cr_in;
   logic m2_neutral_ff;

   always_comb begin
      acc_y_in  = p_yr_ff + p_yg_ff + p_yb_ff;
      acc_cb_in = p_br_ff + p_bg_ff + p_bb_ff + CHROMA_OFFSET;
      acc_cr_in = p_rr_ff + p_rg_ff + p_rb_ff + CHROMA_OFFSET;
   end

   // Stage 3: scale and clamp into the output register.
   logic [RES_W-1:0] luma_ff, cb_ff, cr_ff;

   always_ff @(posedge clock) begin
      if (stage_go[0]) begin
         p_yr_ff <= p_yr_in;
         p_yg_ff <= p_yg_in;
         p_yb_ff <= p_yb_in;
         p_br_ff <= p_br_in;
         p_bg_ff <= p_bg_in;
         p_bb_ff <= p_bb_in;
         p_rr_ff <= p_rr_in;
         p_rg_ff <= p_rg_in;
         p_rb_ff <= p_rb_in;
         m1_neutral_ff <= m1_neutral_in;
      end
      if (stage_go[1]) begin
         acc_y_ff      <= acc_y_in;
         acc_cb_ff     <= acc_cb_in;
         acc_cr_ff     <= acc_cr_in;
         m2_neutral_ff <= m1_neutral_ff;
      end
      if (stage_go[2]) begin
         luma_ff <= clamp8(acc_y_ff);
         cb_ff   <= clamp8(acc_cb_ff);
         cr_ff   <= clamp8(acc_cr_ff);
      end
   end

   assign out_luma        = luma_ff;
   assign out_chroma_blue = cb_ff;
   assign out_chroma_red  = cr_ff;

   // Gray pixels land exactly on the chroma midpoint, and luma clamps at both ends.
   a_gray_chroma: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && m2_neutral_ff |-> acc_cb_ff == CHROMA_OFFSET && acc_cr_ff == CHROMA_OFFSET)
      else $error("gray pixel has nonzero chroma");
   a_luma_low: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && stage_go[2] && acc_y_ff <= 0 |=> luma_ff == '0)
      else $error("luma did not clamp to zero");
   a_luma_high: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && stage_go[2] && acc_y_ff >= ACC_ONE |=> luma_ff == RES_MAX)
      else $error("luma did not clamp to full scale");

endmodule

`default_nettype wire

>>> rtl/linear_rgb_to_srgb_ycbcr_core.sv
// Linear RGB (signed Q4.20) to sRGB-coded JFIF YCbCr, 8 bits per channel.
// Pipeline: the transfer-curve stages, then the matrix stages ending in the output register.
// Throughput: one transaction per clock; every stage is a register with a valid bit,
// and a stalled rsp_ready holds the pipeline without loss, filling bubbles first.
// Reset (synchronous, active high) clears only the valid bits; the curve table is
// constant logic, so the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module linear_rgb_to_srgb_ycbcr_core
   import lrgbycc_pkg::*;
#(
   parameter int CURVE_TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [LIN_W-1:0] req_red_lin,
   input  logic signed [LIN_W-1:0] req_green_lin,
   input  logic signed [LIN_W-1:0] req_blue_lin,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RES_W-1:0]        rsp_luma,
   output logic [RES_W-1:0]        rsp_chroma_blue,
   output logic [RES_W-1:0]        rsp_chroma_red
);

   lin_vec_type   lin_vec;
   gamma_vec_type gamma_vec;
   logic          gamma_valid;
   logic          gamma_ready;

   // Pack the three channels into lanes.
   always_comb begin
      lin_vec[CH_RED]   = req_red_lin;
      lin_vec[CH_GREEN] = req_green_lin;
      lin_vec[CH_BLUE]  = req_blue_lin;
   end

   // Transfer curve on each channel.
   lrgbycc_gamma #(
      .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
   ) u_gamma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_lin    (lin_vec),
      .out_valid (gamma_valid),
      .out_ready (gamma_ready),
      .out_gamma (gamma_vec)
   );

   // Color matrix and output register.
   lrgbycc_matrix u_matrix (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (gamma_valid),
      .in_ready        (gamma_ready),
      .in_gamma        (gamma_vec),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_luma        (rsp_luma),
      .out_chroma_blue (rsp_chroma_blue),
      .out_chroma_red  (rsp_chroma_red)
   );

endmodule

`default_nettype wire

>>> tb/sv/linear_rgb_to_srgb_ycbcr_checker.sv
`timescale 1ns / 1ps

module linear_rgb_to_srgb_ycbcr_checker
   import lrgbycc_pkg::*;
#(
   parameter int CURVE_TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [LIN_W-1:0] req_red_lin,
   input  logic signed [LIN_W-1:0] req_green_lin,
   input  logic signed [LIN_W-1:0] req_blue_lin,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [RES_W-1:0]        rsp_luma,
   input  logic [RES_W-1:0]        rsp_chroma_blue,
   input  logic [RES_W-1:0]        rsp_chroma_red,
   output int                      check_failures,
   output int                      pending_results,
   output int                      results_checked
);

   // Curve table geometry: octaves of magnitude, each split into equal segments.
   localparam int SEG_BITS     = CURVE_TABLE_BITS - 4;
   localparam int SEGS         = 1 << SEG_BITS;
   localparam int FIRST_OCTAVE = 11;
   localparam int OCTAVES      = 13;
   localparam int LAST_NODE    = OCTAVES * SEGS;

   // Linear segment: g = round(m * 206.72), done as (m * 20672 + 50) / 100.
   localparam longint KNEE_LEVEL       = 3282;
   localparam longint LINEAR_SLOPE_NUM = 20672;
   localparam longint LINEAR_SLOPE_DEN = 100;

   // Power segment node: g = round(1055 * Y / 16000) - 0.055 * 2^24.
   localparam longint NODE_SCALE_NUM = 1055;
   localparam longint NODE_SCALE_DEN = 16000;
   localparam longint NODE_OFFSET    = 922747;

   // JFIF matrix in Q16, with the chroma offset at 2^39 and full scale at 2^40.
   localparam longint LUMA_R   = 19595;
   localparam longint LUMA_G   = 38470;
   localparam longint LUMA_B   = 7471;
   localparam longint CB_FROM_R = -11059;
   localparam longint CB_FROM_G = -21709;
   localparam longint CB_FROM_B = 32768;
   localparam longint CR_FROM_R = 32768;
   localparam longint CR_FROM_G = -27439;
   localparam longint CR_FROM_B = -5329;
   localparam longint CHROMA_BIAS = longint'(1) << 39;
   localparam longint FULL_SCALE  = longint'(1) << 40;

   typedef struct packed {
      logic [RES_W-1:0] luma;
      logic [RES_W-1:0] cb;
      logic [RES_W-1:0] cr;
   } ycc_pixel_type;

   longint        gamma_nodes [0:LAST_NODE];
   ycc_pixel_type expected_pixels [$];

   function automatic logic [383:0] raise_power(input logic [383:0] base, input int n);
      logic [383:0] p;
      p = 384'd1;
      for (int k = 0; k < n; k++) begin
         p = p * base;
      end
      return p;
   endfunction

   // Largest Y with Y^12 <= x^5 * 2^236: a floating estimate, then exact correction.
   function automatic longint node_root(input longint x);
      logic [383:0] target;
      real          estimate;
      longint       y;
      target   = raise_power(384'(x), 5) << 236;
      estimate = 268435456.0 * ((real'(x) / 1048576.0) ** (5.0 / 12.0));
      y        = longint'($floor(estimate));
      while (raise_power(384'(y + 1), 12) <= target) begin
         y++;
      end
      while (raise_power(384'(y), 12) > target) begin
         y--;
      end
      return y;
   endfunction

   // The curve is constant, so the node table is built once at time zero.
   initial begin : build_nodes
      int     octave;
      longint x;
      for (int i = 0; i <= LAST_NODE; i++) begin
         octave = FIRST_OCTAVE + i / SEGS;
         x = (longint'(1) << octave) + longint'(i % SEGS) * (longint'(1) << (octave - SEG_BITS));
         gamma_nodes[i] = (NODE_SCALE_NUM * node_root(x) + NODE_SCALE_DEN / 2) / NODE_SCALE_DEN
                          - NODE_OFFSET;
      end
   end

   // Gamma-coded value with 24 fraction bits; negative inputs mirror the curve.
   function automatic longint srgb_encode(input logic [LIN_W-1:0] raw);
      logic   negative;
      longint mag;
      longint rest;
      longint frac;
      longint g;
      int     lead;
      int     shift;
      int     node;
      negative = raw[LIN_W-1];
      mag = longint'({40'd0, raw});
      if (negative) begin
         mag = (longint'(1) << LIN_W) - mag;
      end
      if (mag <= KNEE_LEVEL) begin
         g = (mag * LINEAR_SLOPE_NUM + LINEAR_SLOPE_DEN / 2) / LINEAR_SLOPE_DEN;
      end else begin
         lead = LIN_W - 1;
         while (!mag[lead]) begin
            lead--;
         end
         shift = lead - SEG_BITS;
         rest  = mag - (longint'(1) << lead);
         node  = (lead - FIRST_OCTAVE) * SEGS + int'(rest >>> shift);
         frac  = rest & ((longint'(1) << shift) - 1);
         g = gamma_nodes[node] +
             (((gamma_nodes[node + 1] - gamma_nodes[node]) * frac) >>> shift);
      end
      return negative ? -g : g;
   endfunction

   function automatic logic [RES_W-1:0] clamp_to_byte(input longint acc);
      logic [63:0] bits;
      bits = acc;
      if (acc <= 0) begin
         return '0;
      end else if (acc >= FULL_SCALE) begin
         return '1;
      end
      return bits[39:32];
   endfunction

   function automatic ycc_pixel_type predict_pixel(input logic [LIN_W-1:0] red,
                                                   input logic [LIN_W-1:0] green,
                                                   input logic [LIN_W-1:0] blue);
      longint        r;
      longint        g;
      longint        b;
      ycc_pixel_type px;
      r = srgb_encode(red);
      g = srgb_encode(green);
      b = srgb_encode(blue);
      px.luma = clamp_to_byte(LUMA_R * r + LUMA_G * g + LUMA_B * b);
      px.cb   = clamp_to_byte(CB_FROM_R * r + CB_FROM_G * g + CB_FROM_B * b + CHROMA_BIAS);
      px.cr   = clamp_to_byte(CR_FROM_R * r + CR_FROM_G * g + CR_FROM_B * b + CHROMA_BIAS);
      return px;
   endfunction

   // Predict on each accepted request and compare each accepted response in order.
   always @(posedge clock) begin : monitor
      ycc_pixel_type want;
      int            errors;
      if (reset) begin
         expected_pixels.delete();
         check_failures  <= 0;
         results_checked <= 0;
         pending_results <= 0;
      end else begin
         errors = 0;
         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_pixel(req_red_lin, req_green_lin, req_blue_lin));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: response with no transaction pending: Y %0d Cb %0d Cr %0d",
                        $time, rsp_luma, rsp_chroma_blue, rsp_chroma_red);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_luma !== want.luma) begin
                  $display("%0t: luma expected %0d actual %0d", $time, want.luma, rsp_luma);
                  errors++;
               end
               if (rsp_chroma_blue !== want.cb) begin
                  $display("%0t: chroma_blue expected %0d actual %0d",
                           $time, want.cb, rsp_chroma_blue);
                  errors++;
               end
               if (rsp_chroma_red !== want.cr) begin
                  $display("%0t: chroma_red expected %0d actual %0d",
                           $time, want.cr, rsp_chroma_red);
                  errors++;
               end
            end
            results_checked <= results_checked + 1;
         end
         check_failures  <= check_failures + errors;
         pending_results <= expected_pixels.size();
      end
   end

endmodule

>>> tb/sv/linear_rgb_to_srgb_ycbcr_core_test.sv
`timescale 1ns / 1ps

module linear_rgb_to_srgb_ycbcr_core_test
   import lrgbycc_pkg::*;
();

   localparam int CURVE_BITS       = 8;
   localparam int RANDOM_LEAD      = 150;
   localparam int HOLD_BURST       = 60;
   localparam int RANDOM_MID       = 180;
   localparam int QUIET_TAIL       = 60;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int TAIL_CYCLES      = 20;
   localparam int WATCHDOG_LIMIT   = 1000;

   localparam logic signed [LIN_W-1:0] LIN_MAX  = 24'sh7FFFFF;
   localparam logic signed [LIN_W-1:0] LIN_MIN  = 24'sh800000;
   localparam logic signed [LIN_W-1:0] LIN_ONE  = 24'sh100000;
   localparam logic signed [LIN_W-1:0] LIN_KNEE = 24'sd3282;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [LIN_W-1:0] req_red_lin;
   logic signed [LIN_W-1:0] req_green_lin;
   logic signed [LIN_W-1:0] req_blue_lin;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [RES_W-1:0]        rsp_luma;
   logic [RES_W-1:0]        rsp_chroma_blue;
   logic [RES_W-1:0]        rsp_chroma_red;

   int check_failures;
   int pending_results;
   int results_checked;
   int stall_cycles;
   bit long_hold_req;
   bit quiet_tail;

   linear_rgb_to_srgb_ycbcr_core #(
      .CURVE_TABLE_BITS(CURVE_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_lin    (req_red_lin),
      .req_green_lin  (req_green_lin),
      .req_blue_lin   (req_blue_lin),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_luma       (rsp_luma),
      .rsp_chroma_blue(rsp_chroma_blue),
      .rsp_chroma_red (rsp_chroma_red)
   );

   linear_rgb_to_srgb_ycbcr_checker #(
      .CURVE_TABLE_BITS(CURVE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_lin    (req_red_lin),
      .req_green_lin  (req_green_lin),
      .req_blue_lin   (req_blue_lin),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_luma       (rsp_luma),
      .rsp_chroma_blue(rsp_chroma_blue),
      .rsp_chroma_red (rsp_chroma_red),
      .check_failures (check_failures),
      .pending_results(pending_results),
      .results_checked(results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Ends the run if neither channel completes a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver: short random stalls, one long hold-off on request, none in the tail.
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD_CYCLES; c++) begin
               @(posedge clock);
            end
            rsp_ready <= 1'b1;
            wait (!long_hold_req);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One linear channel value, mixing full range, in-gamut, knee and octave edges.
   function automatic logic [LIN_W-1:0] random_linear();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom();
         3, 4, 5: v = $urandom_range(0, 1 << 20);
         6: v = $urandom_range(0, 16384) - 8192;
         7: v = -$urandom_range(0, 1 << 20);
         8: begin
            v = (1 << $urandom_range(11, 23)) + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) begin
               v = -v;
            end
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = LIN_MAX;
               1: v = LIN_MIN;
               2: v = 0;
               default: v = LIN_ONE;
            endcase
         end
      endcase
      return v[LIN_W-1:0];
   endfunction

   // Offer one pixel and return at the edge where the transaction is accepted.
   task automatic send_pixel(input logic [LIN_W-1:0] red, input logic [LIN_W-1:0] green,
                             input logic [LIN_W-1:0] blue, input bit may_idle);
      if (may_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_red_lin   <= red;
      req_green_lin <= green;
      req_blue_lin  <= blue;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_pixel(input bit may_idle);
      logic [LIN_W-1:0] r;
      logic [LIN_W-1:0] g;
      logic [LIN_W-1:0] b;
      r = random_linear();
      if ($urandom_range(0, 5) == 0) begin
         g = r;
         b = r;
      end else begin
         g = random_linear();
         b = random_linear();
      end
      send_pixel(r, g, b, may_idle);
   endtask

   // Stop offering and wait until every predicted pixel has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_red_lin   <= '0;
      req_green_lin <= '0;
      req_blue_lin  <= '0;
      long_hold_req <= 1'b0;
      quiet_tail    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels: black, white, extremes, knee and octave edges, out of gamut.
      send_pixel('0, '0, '0, 1'b1);
      send_pixel(LIN_ONE, LIN_ONE, LIN_ONE, 1'b1);
      send_pixel(LIN_MAX, LIN_MAX, LIN_MAX, 1'b1);
      send_pixel(LIN_MIN, LIN_MIN, LIN_MIN, 1'b1);
      send_pixel(-LIN_ONE, -LIN_ONE, -LIN_ONE, 1'b1);
      send_pixel(LIN_ONE, '0, '0, 1'b1);
      send_pixel('0, LIN_ONE, '0, 1'b1);
      send_pixel('0, '0, LIN_ONE, 1'b1);
      send_pixel(LIN_KNEE, LIN_KNEE + 24'sd1, -LIN_KNEE, 1'b1);
      send_pixel(-(LIN_KNEE + 24'sd1), 24'sd1, -24'sd1, 1'b1);
      send_pixel(24'sd2047, 24'sd2048, 24'sd2049, 1'b1);
      send_pixel(24'sh400000, 24'sh3FFFFF, 24'sh200000, 1'b1);
      send_pixel(LIN_MAX, LIN_MIN, '0, 1'b1);
      send_pixel(LIN_MIN, LIN_MAX, LIN_MIN, 1'b1);
      send_pixel(24'sd188744, 24'sd188744, 24'sd188744, 1'b1);
      send_pixel(24'sd188744, -24'sd52429, 24'sd943718, 1'b1);

      for (int n = 0; n < RANDOM_LEAD; n++) begin
         send_random_pixel(1'b1);
      end

      // Back-to-back pixels against a long output hold-off fill the pipeline.
      long_hold_req <= 1'b1;
      for (int n = 0; n < HOLD_BURST; n++) begin
         send_random_pixel(1'b0);
      end
      long_hold_req <= 1'b0;

      drain_pipeline();

      for (int n = 0; n < RANDOM_MID; n++) begin
         send_random_pixel(1'b1);
      end

      quiet_tail <= 1'b1;
      for (int n = 0; n < QUIET_TAIL; n++) begin
         send_random_pixel(1'b0);
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d pixels: directed extremes, knee and octave edges,",
               results_checked);
      $display("then random and gray pixels under stalls, a long hold-off and a drain.");
      if (check_failures == 0 && pending_results == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
